### sv/gbr_pkg.sv
package gbr_pkg;

    localparam int MAX_GROUP = 64;
    localparam int ADDR_W    = $clog2(MAX_GROUP);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_OUT
    } state_t;

endpackage

### sv/group_block_reverser.sv
// An item that completes a group or ends the list moves the block to ST_LOAD,
// which reads the first result into rd_data_reg; ST_OUT then gives one result
// per cycle while m_ready is high. Other items are taken back to back; s_ready
// stays low until the last result transfers, as the buffer has one read port.
// Reset (aresetn low, synchronous): buffer empty, group size 2, no result pending;
// buffer contents are not cleared.
module group_block_reverser
    import gbr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_group_size,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_item_value,
    input  logic                     s_list_end,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_out_value,
    output logic                     m_burst_last,
    output logic                     m_sequence_end
);

    logic signed [DATA_W-1:0] mem [MAX_GROUP];
    logic signed [DATA_W-1:0] rd_data_reg;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    size_reg;
    logic [ADDR_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W-1:0]   remain_reg, remain_next;
    logic                rev_reg, rev_next;
    logic                end_reg, end_next;

    logic [CNT_W-1:0]    k_eff;
    logic [CNT_W-1:0]    n_items;
    logic                full;
    logic                emit;
    logic                s_xfer;
    logic                m_xfer;
    logic                last;
    logic [ADDR_W-1:0]   step_idx;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;

    // Zero acts as one, anything above the buffer depth saturates.
    always_comb begin
        priority if (size_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (size_reg > CFG_W'(MAX_GROUP)) begin
            k_eff = CNT_W'(MAX_GROUP);
        end else begin
            k_eff = size_reg[CNT_W-1:0];
        end
    end

    assign s_xfer   = s_valid && s_ready;
    assign m_xfer   = m_valid && m_ready;
    assign n_items  = {1'b0, fill_reg} + CNT_W'(1);
    assign full     = (n_items >= k_eff);
    assign emit     = full || s_list_end;
    assign last     = (remain_reg == '0);
    assign step_idx = rev_reg ? (idx_reg - ADDR_W'(1)) : (idx_reg + ADDR_W'(1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && emit) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_xfer && last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cfg_ready = 1'b1;
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_LOAD: ;
            ST_OUT:  m_valid = 1'b1;
            default: ;
        endcase
    end

    assign m_out_value    = rd_data_reg;
    assign m_burst_last   = last;
    assign m_sequence_end = last && end_reg;

    // Burst bookkeeping and read port control
    always_comb begin
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        remain_next = remain_reg;
        rev_next    = rev_reg;
        end_next    = end_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        if (state_reg == ST_IDLE && s_xfer) begin
            if (emit) begin
                fill_next   = '0;
                rev_next    = full;
                end_next    = s_list_end;
                idx_next    = full ? fill_reg : '0;
                remain_next = fill_reg;
            end else begin
                fill_next = fill_reg + ADDR_W'(1);
            end
        end
        if (state_reg == ST_LOAD) begin
            rd_en = 1'b1;
        end
        // Fetch the next entry on the same edge the current result transfers.
        if (state_reg == ST_OUT && m_xfer && !last) begin
            idx_next    = step_idx;
            remain_next = remain_reg - ADDR_W'(1);
            rd_en       = 1'b1;
            rd_addr     = step_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            mem[fill_reg] <= s_item_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            size_reg   <= GROUP_SIZE_RESET;
            fill_reg   <= '0;
            idx_reg    <= '0;
            remain_reg <= '0;
            rev_reg    <= 1'b0;
            end_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
            rev_reg    <= rev_next;
            end_reg    <= end_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_group_size;
            end
        end
    end

endmodule

### test/group_block_reverser_test.sv
`timescale 1ns / 100ps

module group_block_reverser_test;
    import gbr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 250;
    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     list_end;
    } list_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     burst_last;
        logic                     sequence_end;
    } reordered_word_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_group_size = '0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_item_value   = '0;
    logic                     s_list_end     = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic signed [DATA_W-1:0] m_out_value;
    logic                     m_burst_last;
    logic                     m_sequence_end;

    list_item_t      items_to_send[$];
    reordered_word_t expected_words[$];

    // predictor state
    logic signed [DATA_W-1:0] held_values[MAX_GROUP];
    int                       held_count     = 0;
    logic [CFG_W-1:0]         group_size_reg = GROUP_SIZE_RESET;

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int hold_requests     = 0;
    int hold_served       = 0;
    int hold_left         = 0;
    int mismatch_count    = 0;

    group_block_reverser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_group_size (cfg_group_size),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item_value   (s_item_value),
        .s_list_end     (s_list_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_burst_last   (m_burst_last),
        .m_sequence_end (m_sequence_end)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Hold one value; release the held group reversed once it is full, or in
    // arrival order when the list ends short of a full group.
    function automatic void reverse_groups_step(logic signed [DATA_W-1:0] value,
                                                logic last_in_list);
        int              k;
        int              n;
        bit              flip;
        reordered_word_t word;
        k = group_size_reg;
        if (k == 0) k = 1;
        if (k > MAX_GROUP) k = MAX_GROUP;
        if (held_count < MAX_GROUP) begin
            held_values[held_count] = value;
            held_count++;
        end
        if (held_count >= k) flip = 1'b1;
        else if (last_in_list) flip = 1'b0;
        else return;
        n = held_count;
        for (int i = 0; i < n; i++) begin
            word.value        = held_values[flip ? (n - 1 - i) : i];
            word.burst_last   = (i == n - 1);
            word.sequence_end = (i == n - 1) && last_in_list;
            expected_words.push_back(word);
        end
        held_count = 0;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // driver: predict on each transfer, then offer the next item or idle
    always @(posedge aclk) begin
        list_item_t next;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                reverse_groups_step(s_item_value, s_list_end);
            if (!s_valid || s_ready) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next = items_to_send.pop_front();
                    s_valid      <= 1'b1;
                    s_item_value <= next.value;
                    s_list_end   <= next.list_end;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        reordered_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d", m_out_value));
            end else begin
                want = expected_words.pop_front();
                if (m_out_value !== want.value)
                    report_mismatch($sformatf("out_value %0d, want %0d",
                                              m_out_value, want.value));
                if (m_burst_last !== want.burst_last)
                    report_mismatch($sformatf("burst_last %0b, want %0b",
                                              m_burst_last, want.burst_last));
                if (m_sequence_end !== want.sequence_end)
                    report_mismatch($sformatf("sequence_end %0b, want %0b",
                                              m_sequence_end, want.sequence_end));
            end
        end
    end

    task automatic queue_item(logic signed [DATA_W-1:0] value, logic last_in_list);
        list_item_t item;
        item.value    = value;
        item.list_end = last_in_list;
        items_to_send.push_back(item);
    endtask

    // random-length lists, each closed by list_end
    task automatic queue_lists(int count, int max_len);
        int added;
        int len;
        added = 0;
        while (added < count) begin
            len = $urandom_range(max_len, 1);
            if (len > count - added) len = count - added;
            for (int i = 0; i < len; i++)
                queue_item(random_word(), i == len - 1);
            added += len;
        end
    endtask

    task automatic wait_until_drained();
        do @(negedge aclk);
        while (items_to_send.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_group_size(logic [CFG_W-1:0] size);
        @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_group_size <= size;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        group_size_reg = size;
        @(negedge aclk);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_sizes[8];
        int               k;
        phase_sizes = '{7'd3, 7'd1, 7'd0, 7'd127, 7'd5, 7'd16, 7'd64, 7'd4};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset group size of 2: a full group, a short tail, a full group at list end
        queue_item(WORD_MIN, 1'b0);
        queue_item(WORD_MAX, 1'b0);
        queue_item('1, 1'b1);
        queue_item(32'sh5555_5555, 1'b0);
        queue_item(32'shAAAA_AAAA, 1'b1);
        wait_until_drained();

        // size zero acts as pass-through
        write_group_size(7'd0);
        queue_item('0, 1'b0);
        queue_item(32'sd1, 1'b1);
        wait_until_drained();

        // shrink the group while three values are held
        write_group_size(7'd5);
        queue_item(32'sd10, 1'b0);
        queue_item(32'sd20, 1'b0);
        queue_item(32'sd30, 1'b0);
        wait_until_drained();
        write_group_size(7'd2);
        queue_item(32'sd40, 1'b0);
        wait_until_drained();

        write_group_size(7'd3);
        queue_item(32'sd7, 1'b0);
        queue_item(32'sd8, 1'b1);
        wait_until_drained();

        for (int p = 0; p < 8; p++) begin
            write_group_size(phase_sizes[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
                default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
            endcase
            k = phase_sizes[p];
            if (k == 0) k = 1;
            if (k > MAX_GROUP) k = MAX_GROUP;
            if (k == MAX_GROUP && phase_sizes[p] != 7'(MAX_GROUP)) begin
                // saturated size: one full group of the largest size plus a tail
                for (int i = 0; i < MAX_GROUP + 2; i++)
                    queue_item(random_word(), i == MAX_GROUP + 1);
            end else if (k == MAX_GROUP) begin
                queue_lists(10, 10);
            end else begin
                queue_lists(22, 3 * k + 2);
            end
            // stall the receiver for a long stretch so the input backs up
            if (p == 0) hold_requests++;
            wait_until_drained();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
sv/gbr_pkg.sv
sv/group_block_reverser.sv
test/group_block_reverser_test.sv
